### rtl/core/event_slot_ring_mailbox_core_assert.svh
// Assertion macros for the slot ring mailbox core.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef EVENT_SLOT_RING_MAILBOX_CORE_ASSERT_SVH
`define EVENT_SLOT_RING_MAILBOX_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ESRM_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESRM_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/esrm_pkg.sv
package esrm_pkg;

  // Fixed field widths of the request and result channels and of the slot status
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned ETYPE_W    = 8;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned TYPE_OUT_W = 8;
  localparam int unsigned STATUS_W   = 2;

  // Request operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_RESERVE = 2'd0,
    MODE_POST    = 2'd1,
    MODE_TAKE    = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  // Per-slot status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_FREE     = 2'd0,
    STAT_RESERVED = 2'd1,
    STAT_COMPLETE = 2'd2,
    STAT_USED     = 2'd3
  } status_t;

endpackage

### rtl/core/esrm_if.sv
// Request channel
interface esrm_in_if;
  logic                              valid;
  logic                              ready;
  esrm_pkg::mode_t                   mode;
  logic [esrm_pkg::ETYPE_W-1:0]      event_type;
  logic [esrm_pkg::SLOT_W-1:0]       slot;

  modport source (output valid, mode, event_type, slot, input ready);
  modport sink   (input valid, mode, event_type, slot, output ready);
endinterface

// Result channel
interface esrm_out_if;
  logic                              valid;
  logic                              ready;
  logic                              granted;
  logic [esrm_pkg::SLOT_W-1:0]       slot_out;
  logic [esrm_pkg::TYPE_OUT_W-1:0]   type_out;

  modport source (output valid, granted, slot_out, type_out, input ready);
  modport sink   (input valid, granted, slot_out, type_out, output ready);
endinterface

### rtl/core/esrm_ram.sv
module esrm_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/event_slot_ring_mailbox_core.sv
// Slot ring mailbox.
// in_ch carries requests (mode, event_type, slot); out_ch returns one result
// per request (granted, slot_out, type_out). Both use valid/ready, a transfer
// happens when both are high.
// Reserve claims the slot at the write index if free and stores its type;
// post marks a named slot complete; take hands out the slot at the read
// index if complete; release frees a named slot.
// A request is held in a register while the memories are read, then executes
// into the output register. The slot status and type memories are read when
// a request is accepted and written back when it executes, and a new request
// is taken only once the previous write-back is done.
// Reset: indices go to zero and a clearing pass writes every status entry
// to free, all SLOTS (64 by default) of them; in_ch.ready stays low meanwhile.
// Stall: a result waits in the output register while the next request is
// accepted and read; that request then holds until the result is taken.
`include "event_slot_ring_mailbox_core_assert.svh"

module event_slot_ring_mailbox_core #(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned TYPE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  esrm_in_if.sink     in_ch,
  esrm_out_if.source  out_ch
);

  localparam int unsigned IW = $clog2(SLOTS);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t                            state_r, state_nxt;
  logic [IW-1:0]                     clr_idx_r, clr_idx_nxt;
  logic [IW-1:0]                     wr_idx_r, wr_idx_nxt;
  logic [IW-1:0]                     rd_idx_r, rd_idx_nxt;
  logic                              out_valid_r, out_valid_nxt;

  esrm_pkg::mode_t                   req_mode_r;
  logic [TYPE_BITS-1:0]              req_type_r;
  logic [esrm_pkg::SLOT_W-1:0]       req_slot_r;
  logic                              out_granted_r, out_granted_nxt;
  logic [esrm_pkg::SLOT_W-1:0]       out_slot_r, out_slot_nxt;
  logic [esrm_pkg::TYPE_OUT_W-1:0]   out_type_r, out_type_nxt;

  logic                              accept;
  logic                              exec_go;
  logic                              clearing;
  logic                              clr_last;

  logic                              stat_we;
  logic [IW-1:0]                     stat_waddr;
  logic [esrm_pkg::STATUS_W-1:0]     stat_wdata;
  logic [IW-1:0]                     stat_raddr;
  logic [esrm_pkg::STATUS_W-1:0]     stat_rdata;
  logic                              op_st_we;
  logic [IW-1:0]                     op_st_addr;
  logic [esrm_pkg::STATUS_W-1:0]     op_st_data;

  logic                              type_we;
  logic [TYPE_BITS-1:0]              type_rdata;

  logic [IW-1:0]                     wr_idx_inc;
  logic [IW-1:0]                     rd_idx_inc;
  logic                              slot_in_range;

  // Handshake
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign exec_go     = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);
  assign clearing    = (state_r == ST_CLEAR);
  assign clr_last    = (clr_idx_r == IW'(SLOTS - 1));

  // Ring index increments with wrap
  assign wr_idx_inc = (wr_idx_r == IW'(SLOTS - 1)) ? '0 : wr_idx_r + IW'(1);
  assign rd_idx_inc = (rd_idx_r == IW'(SLOTS - 1)) ? '0 : rd_idx_r + IW'(1);
  assign slot_in_range = (32'(req_slot_r) < 32'(SLOTS));

  // Read the slot each request needs: take looks at the read index
  assign stat_raddr = (in_ch.mode == esrm_pkg::MODE_TAKE) ? rd_idx_r : wr_idx_r;

  // Decide the operation from the read status
  always_comb begin
    op_st_we        = 1'b0;
    op_st_addr      = wr_idx_r;
    op_st_data      = esrm_pkg::STAT_RESERVED;
    type_we         = 1'b0;
    wr_idx_nxt      = wr_idx_r;
    rd_idx_nxt      = rd_idx_r;
    out_granted_nxt = 1'b0;
    out_slot_nxt    = '0;
    out_type_nxt    = '0;
    case (req_mode_r)
      esrm_pkg::MODE_RESERVE: begin
        if (stat_rdata == esrm_pkg::STAT_FREE) begin
          op_st_we        = 1'b1;
          type_we         = 1'b1;
          wr_idx_nxt      = wr_idx_inc;
          out_granted_nxt = 1'b1;
          out_slot_nxt    = esrm_pkg::SLOT_W'(wr_idx_r);
        end
      end
      esrm_pkg::MODE_POST, esrm_pkg::MODE_RELEASE: begin
        op_st_we        = slot_in_range;
        op_st_addr      = IW'(req_slot_r);
        op_st_data      = (req_mode_r == esrm_pkg::MODE_POST) ?
                          esrm_pkg::STAT_COMPLETE : esrm_pkg::STAT_FREE;
        out_granted_nxt = 1'b1;
        out_slot_nxt    = req_slot_r;
      end
      esrm_pkg::MODE_TAKE: begin
        if (stat_rdata == esrm_pkg::STAT_COMPLETE) begin
          op_st_we        = 1'b1;
          op_st_addr      = rd_idx_r;
          op_st_data      = esrm_pkg::STAT_USED;
          rd_idx_nxt      = rd_idx_inc;
          out_granted_nxt = 1'b1;
          out_slot_nxt    = esrm_pkg::SLOT_W'(rd_idx_r);
          out_type_nxt    = esrm_pkg::TYPE_OUT_W'(type_rdata);
        end
      end
      default: begin
        op_st_we = 1'b0;
      end
    endcase
  end

  // Share the status write port between clearing pass and write-back
  assign stat_we    = clearing || (exec_go && op_st_we);
  assign stat_waddr = clearing ? clr_idx_r : op_st_addr;
  assign stat_wdata = clearing ? esrm_pkg::STAT_FREE : op_st_data;

  esrm_ram #(
    .DEPTH (SLOTS),
    .WIDTH (esrm_pkg::STATUS_W)
  ) u_status_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (stat_waddr),
    .wdata (stat_wdata),
    .re    (accept),
    .raddr (stat_raddr),
    .rdata (stat_rdata)
  );

  esrm_ram #(
    .DEPTH (SLOTS),
    .WIDTH (TYPE_BITS)
  ) u_type_ram (
    .clk   (clk),
    .we    (exec_go && type_we),
    .waddr (wr_idx_r),
    .wdata (req_type_r),
    .re    (accept),
    .raddr (rd_idx_r),
    .rdata (type_rdata)
  );

  // Sequence: clear, wait for a request, execute
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + IW'(1);
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Output valid: load on execute, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_go) begin
        wr_idx_r <= wr_idx_nxt;
        rd_idx_r <= rd_idx_nxt;
      end
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode_r <= in_ch.mode;
      req_type_r <= TYPE_BITS'(in_ch.event_type);
      req_slot_r <= in_ch.slot;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_granted_r <= out_granted_nxt;
      out_slot_r    <= out_slot_nxt;
      out_type_r    <= out_type_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.granted  = out_granted_r;
  assign out_ch.slot_out = out_slot_r;
  assign out_ch.type_out = out_type_r;

  // Checks
  `ESRM_ASSERT_NEXT(a_result_from_exec, !out_valid_r && !exec_go, !out_valid_r,
    "result appeared without an execute cycle")
  `ESRM_ASSERT_NEXT(a_clear_done, clearing && clr_last, state_r == ST_IDLE,
    "clearing pass did not end in idle")
  `ESRM_ASSERT_NEXT(a_take_advances,
    exec_go && (req_mode_r == esrm_pkg::MODE_TAKE) && out_granted_nxt,
    rd_idx_r != $past(rd_idx_r) && out_ch.granted,
    "granted take did not advance the read index")
  `ESRM_ASSERT_NOW(a_no_accept_busy, accept, !clearing && (state_r != ST_EXEC),
    "request accepted while clearing or executing")

endmodule

### verif/testbench.sv
module testbench;

  localparam int unsigned NUM_SLOTS    = 64;
  localparam int unsigned RANDOM_REQS  = 1875;
  localparam int unsigned CALM_REQS    = 300;
  localparam int unsigned HOLD_CYCLES  = 40;
  localparam int unsigned QUIET_LIMIT  = 500;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    esrm_pkg::mode_t                 mode;
    logic [esrm_pkg::ETYPE_W-1:0]    event_type;
    logic [esrm_pkg::SLOT_W-1:0]     slot;
  } request_t;

  typedef struct packed {
    logic                            granted;
    logic [esrm_pkg::SLOT_W-1:0]     slot_out;
    logic [esrm_pkg::TYPE_OUT_W-1:0] type_out;
  } result_t;

  typedef struct packed {
    esrm_pkg::mode_t                 mode;
    logic [esrm_pkg::ETYPE_W-1:0]    event_type;
    logic [esrm_pkg::SLOT_W-1:0]     slot;
    bit                              typed;
    logic                            granted;
    logic [esrm_pkg::SLOT_W-1:0]     slot_out;
    logic [esrm_pkg::TYPE_OUT_W-1:0] type_out;
  } directed_row_t;

  localparam int unsigned DIRECTED_ROWS = 23;

  // Opening sequence; rows with typed set carry their own expected result
  localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{esrm_pkg::MODE_TAKE,    8'h00, 6'd0,  1'b1, 1'b0, 6'd0,  8'h00}, // empty ring refuses take
    '{esrm_pkg::MODE_RESERVE, 8'hFF, 6'd0,  1'b1, 1'b1, 6'd0,  8'h00},
    '{esrm_pkg::MODE_RESERVE, 8'h00, 6'd0,  1'b1, 1'b1, 6'd1,  8'h00},
    '{esrm_pkg::MODE_TAKE,    8'h00, 6'd0,  1'b1, 1'b0, 6'd0,  8'h00}, // slot 0 only reserved
    '{esrm_pkg::MODE_POST,    8'h00, 6'd0,  1'b1, 1'b1, 6'd0,  8'h00},
    '{esrm_pkg::MODE_TAKE,    8'h00, 6'd0,  1'b1, 1'b1, 6'd0,  8'hFF},
    '{esrm_pkg::MODE_TAKE,    8'h00, 6'd0,  1'b1, 1'b0, 6'd0,  8'h00},
    '{esrm_pkg::MODE_POST,    8'h00, 6'd63, 1'b1, 1'b1, 6'd63, 8'h00}, // post a free slot
    '{esrm_pkg::MODE_RELEASE, 8'h00, 6'd63, 1'b1, 1'b1, 6'd63, 8'h00},
    '{esrm_pkg::MODE_POST,    8'h00, 6'd2,  1'b1, 1'b1, 6'd2,  8'h00},
    '{esrm_pkg::MODE_RESERVE, 8'hA5, 6'd0,  1'b1, 1'b0, 6'd0,  8'h00}, // write slot not free
    '{esrm_pkg::MODE_RELEASE, 8'h00, 6'd2,  1'b1, 1'b1, 6'd2,  8'h00},
    '{esrm_pkg::MODE_RESERVE, 8'hA5, 6'd0,  1'b1, 1'b1, 6'd2,  8'h00},
    '{esrm_pkg::MODE_POST,    8'h00, 6'd1,  1'b1, 1'b1, 6'd1,  8'h00},
    '{esrm_pkg::MODE_TAKE,    8'h00, 6'd0,  1'b1, 1'b1, 6'd1,  8'h00},
    '{esrm_pkg::MODE_POST,    8'h00, 6'd2,  1'b1, 1'b1, 6'd2,  8'h00},
    '{esrm_pkg::MODE_TAKE,    8'h00, 6'd0,  1'b1, 1'b1, 6'd2,  8'hA5},
    '{esrm_pkg::MODE_RELEASE, 8'h00, 6'd0,  1'b1, 1'b1, 6'd0,  8'h00}, // free a used slot
    '{esrm_pkg::MODE_POST,    8'h00, 6'd0,  1'b0, 1'b0, 6'd0,  8'h00},
    '{esrm_pkg::MODE_RESERVE, 8'h5A, 6'd0,  1'b0, 1'b0, 6'd0,  8'h00},
    '{esrm_pkg::MODE_RELEASE, 8'h00, 6'd3,  1'b0, 1'b0, 6'd0,  8'h00}, // free a reserved slot
    '{esrm_pkg::MODE_POST,    8'h00, 6'd1,  1'b0, 1'b0, 6'd0,  8'h00}, // repost a used slot
    '{esrm_pkg::MODE_RESERVE, 8'h3C, 6'd0,  1'b0, 1'b0, 6'd0,  8'h00}
  };

  logic clk;
  logic rst_n;

  esrm_in_if  in_ch ();
  esrm_out_if out_ch ();

  event_slot_ring_mailbox_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Mailbox mirror
  esrm_pkg::status_t            slot_state [NUM_SLOTS];
  logic [esrm_pkg::ETYPE_W-1:0] slot_type  [NUM_SLOTS];
  bit                           type_known [NUM_SLOTS];
  logic [esrm_pkg::SLOT_W-1:0]  wr_idx;
  logic [esrm_pkg::SLOT_W-1:0]  rd_idx;

  // Slots held by the producer and consumer sides of the traffic
  logic [esrm_pkg::SLOT_W-1:0] reserved_slots [$];
  logic [esrm_pkg::SLOT_W-1:0] taken_slots [$];

  result_t pending_results [$];
  int      mismatches;
  bit      idling_allowed;
  bit      hold_results_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  // Advance the mirror by one request and return its result
  function automatic result_t predict_request(request_t req);
    result_t res = '0;
    case (req.mode)
      esrm_pkg::MODE_RESERVE: begin
        if (slot_state[wr_idx] == esrm_pkg::STAT_FREE) begin
          slot_state[wr_idx] = esrm_pkg::STAT_RESERVED;
          slot_type[wr_idx]  = req.event_type;
          type_known[wr_idx] = 1'b1;
          res.granted  = 1'b1;
          res.slot_out = wr_idx;
          wr_idx       = wr_idx + esrm_pkg::SLOT_W'(1);
        end
      end
      esrm_pkg::MODE_POST, esrm_pkg::MODE_RELEASE: begin
        res.granted  = 1'b1;
        res.slot_out = req.slot;
        slot_state[req.slot] = (req.mode == esrm_pkg::MODE_POST) ?
                               esrm_pkg::STAT_COMPLETE : esrm_pkg::STAT_FREE;
      end
      default: begin
        if (slot_state[rd_idx] == esrm_pkg::STAT_COMPLETE) begin
          slot_state[rd_idx] = esrm_pkg::STAT_USED;
          res.granted  = 1'b1;
          res.slot_out = rd_idx;
          res.type_out = slot_type[rd_idx];
          rd_idx       = rd_idx + esrm_pkg::SLOT_W'(1);
        end
      end
    endcase
    return res;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(request_t req, bit typed, result_t want);
    result_t res;
    res = predict_request(req);
    if (res.granted && req.mode == esrm_pkg::MODE_RESERVE)
      reserved_slots.push_back(res.slot_out);
    if (res.granted && req.mode == esrm_pkg::MODE_TAKE)
      taken_slots.push_back(res.slot_out);
    if (typed) res = want;
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= req.mode;
    in_ch.event_type <= req.event_type;
    in_ch.slot       <= req.slot;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(res);
  endtask

  task automatic pause_requests(int unsigned cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Mostly reserve/post/take/release traffic, with some stray posts and releases
  function automatic request_t pick_request(int unsigned reserve_share);
    request_t    req;
    int unsigned pick;
    int unsigned part;
    int unsigned idx;
    req.mode       = esrm_pkg::MODE_TAKE;
    req.event_type = esrm_pkg::ETYPE_W'($urandom_range(0, 255));
    req.slot       = esrm_pkg::SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // stray post; only slots with a stored type may become complete
      if ($urandom_range(0, 1) != 0) req.slot = rd_idx;
      req.mode = type_known[req.slot] ? esrm_pkg::MODE_POST : esrm_pkg::MODE_RELEASE;
    end else if (pick < 15) begin
      if ($urandom_range(0, 1) != 0) req.slot = wr_idx;
      req.mode = esrm_pkg::MODE_RELEASE;
    end else if (pick < 15 + reserve_share) begin
      req.mode = esrm_pkg::MODE_RESERVE;
    end else begin
      part = (pick - 15 - reserve_share) % 3;
      if (part == 0 && reserved_slots.size() != 0) begin
        idx      = $urandom_range(0, reserved_slots.size() - 1);
        req.slot = reserved_slots[idx];
        reserved_slots.delete(idx);
        req.mode = esrm_pkg::MODE_POST;
      end else if (part == 1 && taken_slots.size() != 0) begin
        idx      = $urandom_range(0, taken_slots.size() - 1);
        req.slot = taken_slots[idx];
        taken_slots.delete(idx);
        req.mode = esrm_pkg::MODE_RELEASE;
      end
    end
    return req;
  endfunction

  // Check results against the oldest expectation; stall in bursts
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    result_t     want;
    stall_left = 0;
    hold_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending", int'(out_ch.slot_out), 0);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.granted !== want.granted)
            report_mismatch("granted", int'(out_ch.granted), int'(want.granted));
          if (out_ch.slot_out !== want.slot_out)
            report_mismatch("slot_out", int'(out_ch.slot_out), int'(want.slot_out));
          if (out_ch.type_out !== want.type_out)
            report_mismatch("type_out", int'(out_ch.type_out), int'(want.type_out));
        end
      end
      if (hold_results_req) begin
        hold_results_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idling_allowed && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stop the run when nothing moves on either channel for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    request_t    req;
    result_t     want;
    int unsigned reserve_share;
    mismatches       = 0;
    idling_allowed   = 1'b1;
    hold_results_req = 1'b0;
    reserve_share    = 30;
    wr_idx           = '0;
    rd_idx           = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_state[i] = esrm_pkg::STAT_FREE;
      slot_type[i]  = '0;
      type_known[i] = 1'b0;
    end
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= esrm_pkg::MODE_RESERVE;
    in_ch.event_type <= '0;
    in_ch.slot       <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      req.mode       = DIRECTED[i].mode;
      req.event_type = DIRECTED[i].event_type;
      req.slot       = DIRECTED[i].slot;
      want.granted   = DIRECTED[i].granted;
      want.slot_out  = DIRECTED[i].slot_out;
      want.type_out  = DIRECTED[i].type_out;
      if (idling_allowed && $urandom_range(0, 3) == 0) pause_requests($urandom_range(1, 3));
      send_request(req, DIRECTED[i].typed, want);
    end

    // Random traffic in segments of varying mix and idling
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 100 == 0) begin
        reserve_share  = $urandom_range(18, 42);
        idling_allowed = (i < RANDOM_REQS - CALM_REQS) && ($urandom_range(0, 2) != 0);
      end
      if (i == 600) hold_results_req = 1'b1;
      if (idling_allowed && $urandom_range(0, 5) == 0) pause_requests($urandom_range(1, 3));
      req = pick_request(reserve_share);
      send_request(req, 1'b0, want);
    end
    in_ch.valid <= 1'b0;

    // Drain outstanding results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
